>>> hdl/swmq_pkg.sv
// shared constants, codes and types for the min-query stack
package swmq_pkg;

   localparam int DEPTH  = 64;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int ADDR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
   localparam int WORD_W = 32;
   localparam int OP_W   = 2;
   localparam int ST_W   = 2;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH = 2'd0,
      OP_POP  = 2'd1,
      OP_PEEK = 2'd2,
      OP_MIN  = 2'd3
   } op_type;

   typedef enum logic [ST_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic load;
      logic first;
   } cmp_ctl_type;

endpackage

>>> hdl/swmq_ram.sv
// single write port, single registered read port entry memory
module swmq_ram #(
   parameter int DATA_W = 32,
   parameter int ADDR_W = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [2**ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/swmq_min_unit.sv
// shared signed compare and select unit that tracks the running minimum
module swmq_min_unit (
   input  logic                                    clock,
   input  swmq_pkg::cmp_ctl_type                   ctl,
   input  logic signed [swmq_pkg::WORD_W-1:0]      data,
   output logic signed [swmq_pkg::WORD_W-1:0]      min_value
);

   logic signed [swmq_pkg::WORD_W-1:0] min_ff;
   logic signed [swmq_pkg::WORD_W-1:0] min_in;

   always_comb begin
      min_in = min_ff;
      if (ctl.load) begin
         if (ctl.first || (data < min_ff)) begin
            min_in = data;
         end
      end
   end

   always_ff @(posedge clock) begin
      min_ff <= min_in;
   end

   assign min_value = min_ff;

endmodule

>>> hdl/stack_with_min_query_unit.sv
// top level: lifo stack with pop, peek and minimum query under a small sequencer
// push and any error go from S_IDLE straight to S_DONE; pop and peek read the top entry
// in S_SCAN, and a minimum query scans every entry in S_SCAN before it reaches S_DONE
// the minimum query cost is set by one memory read port feeding one compare unit
// one request at a time; a new one is taken while the last response waits
// synchronous active-high reset empties the stack; memory contents are not cleared
module stack_with_min_query_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] push_value
   input  logic [1:0]  req_tuser,   // [1:0] opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] result_value
   output logic [2:0]  rsp_tuser    // [1:0] status, [2] now_empty
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DONE
   } state_type;

   state_type                           state_ff, state_in;
   logic [swmq_pkg::CNT_W-1:0]          count_ff, count_in;
   logic [swmq_pkg::CNT_W-1:0]          idx_ff, idx_in;
   logic [swmq_pkg::CNT_W-1:0]          end_ff, end_in;
   logic                                first_ff, first_in;
   swmq_pkg::status_type                status_ff, status_in;
   logic                                zero_ff, zero_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [swmq_pkg::WORD_W-1:0]         rsp_data_ff, rsp_data_in;
   logic [2:0]                          rsp_user_ff, rsp_user_in;

   logic                                req_accept;
   swmq_pkg::op_type                    op;
   logic                                is_full;
   logic                                stack_empty;
   logic [swmq_pkg::CNT_W-1:0]          count_m1;
   logic                                wr_en;
   logic                                rd_en;
   logic [swmq_pkg::ADDR_W-1:0]         rd_addr;
   logic [swmq_pkg::WORD_W-1:0]         rd_data;
   logic signed [swmq_pkg::WORD_W-1:0]  min_value;
   swmq_pkg::cmp_ctl_type               cmp_ctl;

   assign req_tready  = (state_ff == S_IDLE);
   assign req_accept  = req_tvalid && req_tready;
   assign op          = swmq_pkg::op_type'(req_tuser[1:0]);
   assign is_full     = (count_ff == swmq_pkg::CNT_W'(swmq_pkg::DEPTH));
   assign stack_empty = (count_ff == '0);
   assign count_m1    = count_ff - swmq_pkg::CNT_W'(1);

   // memory port control
   always_comb begin
      wr_en   = 1'b0;
      rd_en   = 1'b0;
      rd_addr = idx_ff[swmq_pkg::ADDR_W-1:0];
      if (state_ff == S_IDLE && req_accept) begin
         case (op) inside
            swmq_pkg::OP_PUSH: begin
               wr_en = !is_full;
            end
            swmq_pkg::OP_POP, swmq_pkg::OP_PEEK: begin
               rd_en   = !stack_empty;
               rd_addr = count_m1[swmq_pkg::ADDR_W-1:0];
            end
            default: begin
               rd_en   = !stack_empty;
               rd_addr = '0;
            end
         endcase
      end else if (state_ff == S_SCAN && idx_ff != end_ff) begin
         rd_en = 1'b1;
      end
   end

   swmq_ram #(
      .DATA_W (swmq_pkg::WORD_W),
      .ADDR_W (swmq_pkg::ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[swmq_pkg::ADDR_W-1:0]),
      .wr_data (req_tdata),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign cmp_ctl.load  = (state_ff == S_SCAN);
   assign cmp_ctl.first = first_ff;

   swmq_min_unit u_min (
      .clock     (clock),
      .ctl       (cmp_ctl),
      .data      ($signed(rd_data)),
      .min_value (min_value)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      end_in       = end_ff;
      first_in     = first_ff;
      status_in    = status_ff;
      zero_in      = zero_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               status_in = swmq_pkg::ST_OK;
               zero_in   = 1'b1;
               first_in  = 1'b1;
               state_in  = S_DONE;
               case (op) inside
                  swmq_pkg::OP_PUSH: begin
                     if (is_full) begin
                        status_in = swmq_pkg::ST_FULL;
                     end else begin
                        count_in = count_ff + swmq_pkg::CNT_W'(1);
                     end
                  end
                  swmq_pkg::OP_POP, swmq_pkg::OP_PEEK: begin
                     if (stack_empty) begin
                        status_in = swmq_pkg::ST_EMPTY;
                     end else begin
                        zero_in  = 1'b0;
                        state_in = S_SCAN;
                        idx_in   = count_ff;
                        end_in   = count_ff;
                        if (op == swmq_pkg::OP_POP) begin
                           count_in = count_m1;
                        end
                     end
                  end
                  default: begin
                     if (stack_empty) begin
                        status_in = swmq_pkg::ST_EMPTY;
                     end else begin
                        zero_in  = 1'b0;
                        state_in = S_SCAN;
                        idx_in   = swmq_pkg::CNT_W'(1);
                        end_in   = count_ff;
                     end
                  end
               endcase
            end
         end
         S_SCAN: begin
            first_in = 1'b0;
            if (idx_ff != end_ff) begin
               idx_in = idx_ff + swmq_pkg::CNT_W'(1);
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = zero_ff ? '0 : min_value;
               rsp_user_in  = {stack_empty, status_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      end_ff      <= end_in;
      first_ff    <= first_in;
      status_ff   <= status_in;
      zero_ff     <= zero_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= swmq_pkg::CNT_W'(swmq_pkg::DEPTH))
      else $error("entry count above depth");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (req_accept && op == swmq_pkg::OP_PUSH && !is_full)
      |=> count_ff == $past(count_ff) + swmq_pkg::CNT_W'(1))
      else $error("accepted push did not grow the stack");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (idx_ff <= end_ff && end_ff <= count_ff + swmq_pkg::CNT_W'(1)))
      else $error("scan index past its end");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[1:0] != swmq_pkg::ST_OK) |-> rsp_tdata == '0)
      else $error("error response carries nonzero value");

endmodule

>>> verif/testbench.sv
// testbench for the min-query stack: directed table, then random requests vs a shadow stack
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_REQUESTS = 950;
   localparam int SEGMENT_LEN     = 120;
   localparam int CALM_TAIL       = 150;
   localparam int HOLD_OFF_AT     = 400;
   localparam int HOLD_OFF_CYCLES = 300;

   typedef struct packed {
      logic [swmq_pkg::WORD_W-1:0] value;
      swmq_pkg::status_type        status;
      logic                        now_empty;
   } stack_reply_type;

   typedef struct packed {
      swmq_pkg::op_type            op;
      logic [swmq_pkg::WORD_W-1:0] word;
      logic                        typed;
      stack_reply_type             reply;
   } stack_row_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;   // [31:0] push_value
   logic [1:0]  req_tuser  = swmq_pkg::OP_PUSH;   // [1:0] opcode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;   // [31:0] result_value
   logic [2:0]  rsp_tuser;   // [1:0] status, [2] now_empty

   logic signed [swmq_pkg::WORD_W-1:0] shadow_stack [swmq_pkg::DEPTH];
   int                                 shadow_depth = 0;
   stack_reply_type                    expected_replies [$];
   stack_row_type                      directed_ops [$];
   int                                 mismatches = 0;
   logic                               calm_tail = 1'b0;
   logic                               hold_off_pending = 1'b0;

   stack_with_min_query_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic stack_reply_type apply_stack_op(input swmq_pkg::op_type op,
                                                      input logic [swmq_pkg::WORD_W-1:0] word);
      stack_reply_type                    reply;
      logic signed [swmq_pkg::WORD_W-1:0] lowest;
      reply.value  = '0;
      reply.status = swmq_pkg::ST_OK;
      if (op == swmq_pkg::OP_PUSH) begin
         if (shadow_depth >= swmq_pkg::DEPTH) begin
            reply.status = swmq_pkg::ST_FULL;
         end else begin
            shadow_stack[shadow_depth] = word;
            shadow_depth++;
         end
      end else if (shadow_depth == 0) begin
         reply.status = swmq_pkg::ST_EMPTY;
      end else if (op == swmq_pkg::OP_POP) begin
         shadow_depth--;
         reply.value = shadow_stack[shadow_depth];
      end else if (op == swmq_pkg::OP_PEEK) begin
         reply.value = shadow_stack[shadow_depth - 1];
      end else begin
         lowest = shadow_stack[0];
         for (int i = 1; i < shadow_depth; i++) begin
            if (shadow_stack[i] < lowest) lowest = shadow_stack[i];
         end
         reply.value = lowest;
      end
      reply.now_empty = (shadow_depth == 0);
      return reply;
   endfunction

   function automatic void add_op(input swmq_pkg::op_type op,
                                  input logic [swmq_pkg::WORD_W-1:0] word,
                                  input logic typed,
                                  input logic [swmq_pkg::WORD_W-1:0] value,
                                  input swmq_pkg::status_type status, input logic now_empty);
      stack_row_type row;
      row.op    = op;
      row.word  = word;
      row.typed = typed;
      row.reply = '{value: value, status: status, now_empty: now_empty};
      directed_ops.push_back(row);
   endfunction

   task automatic send_request(input swmq_pkg::op_type op,
                               input logic [swmq_pkg::WORD_W-1:0] word,
                               input logic typed, input stack_reply_type typed_reply);
      stack_reply_type predicted;
      if (!calm_tail && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= word;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = apply_stack_op(op, word);
      expected_replies.push_back(typed ? typed_reply : predicted);
      @(negedge clock);
   endtask

   initial begin
      swmq_pkg::op_type            op;
      logic [swmq_pkg::WORD_W-1:0] word;
      int unsigned                 pick;
      int unsigned                 push_w;
      int unsigned                 pop_w;
      int unsigned                 peek_w;

      // empty stack errors, signed extremes, equal minimums, ignored data
      add_op(swmq_pkg::OP_POP,  32'h0000_0000, 1'b1, 32'h0000_0000, swmq_pkg::ST_EMPTY, 1'b1);
      add_op(swmq_pkg::OP_PEEK, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, swmq_pkg::ST_EMPTY, 1'b1);
      add_op(swmq_pkg::OP_MIN,  32'h8000_0000, 1'b1, 32'h0000_0000, swmq_pkg::ST_EMPTY, 1'b1);
      add_op(swmq_pkg::OP_PUSH, 32'h7FFF_FFFF, 1'b1, 32'h0000_0000, swmq_pkg::ST_OK,    1'b0);
      add_op(swmq_pkg::OP_PUSH, 32'h8000_0000, 1'b1, 32'h0000_0000, swmq_pkg::ST_OK,    1'b0);
      add_op(swmq_pkg::OP_PUSH, 32'h0000_0000, 1'b1, 32'h0000_0000, swmq_pkg::ST_OK,    1'b0);
      add_op(swmq_pkg::OP_PUSH, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, swmq_pkg::ST_OK,    1'b0);
      add_op(swmq_pkg::OP_MIN,  32'h0000_0000, 1'b1, 32'h8000_0000, swmq_pkg::ST_OK,    1'b0);
      add_op(swmq_pkg::OP_PEEK, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF, swmq_pkg::ST_OK,    1'b0);
      add_op(swmq_pkg::OP_POP,  32'h0000_0000, 1'b1, 32'hFFFF_FFFF, swmq_pkg::ST_OK,    1'b0);
      add_op(swmq_pkg::OP_POP,  32'h0000_0000, 1'b1, 32'h0000_0000, swmq_pkg::ST_OK,    1'b0);
      add_op(swmq_pkg::OP_MIN,  32'h0000_0000, 1'b1, 32'h8000_0000, swmq_pkg::ST_OK,    1'b0);
      add_op(swmq_pkg::OP_POP,  32'h0000_0000, 1'b1, 32'h8000_0000, swmq_pkg::ST_OK,    1'b0);
      add_op(swmq_pkg::OP_MIN,  32'h0000_0000, 1'b1, 32'h7FFF_FFFF, swmq_pkg::ST_OK,    1'b0);
      add_op(swmq_pkg::OP_PUSH, 32'h7FFF_FFFF, 1'b1, 32'h0000_0000, swmq_pkg::ST_OK,    1'b0);
      add_op(swmq_pkg::OP_MIN,  32'h0000_0000, 1'b1, 32'h7FFF_FFFF, swmq_pkg::ST_OK,    1'b0);
      add_op(swmq_pkg::OP_POP,  32'h0000_0000, 1'b1, 32'h7FFF_FFFF, swmq_pkg::ST_OK,    1'b0);
      add_op(swmq_pkg::OP_POP,  32'h0000_0000, 1'b1, 32'h7FFF_FFFF, swmq_pkg::ST_OK,    1'b1);
      add_op(swmq_pkg::OP_PEEK, 32'h1234_5678, 1'b1, 32'h0000_0000, swmq_pkg::ST_EMPTY, 1'b1);
      add_op(swmq_pkg::OP_PUSH, 32'h5A5A_5A5A, 1'b0, 32'h0000_0000, swmq_pkg::ST_OK,    1'b0);
      add_op(swmq_pkg::OP_PUSH, 32'hA5A5_A5A5, 1'b0, 32'h0000_0000, swmq_pkg::ST_OK,    1'b0);
      add_op(swmq_pkg::OP_POP,  32'hFFFF_FFFF, 1'b0, 32'h0000_0000, swmq_pkg::ST_OK,    1'b0);
      add_op(swmq_pkg::OP_PEEK, 32'h0000_0000, 1'b0, 32'h0000_0000, swmq_pkg::ST_OK,    1'b0);
      add_op(swmq_pkg::OP_MIN,  32'h0F0F_0F0F, 1'b0, 32'h0000_0000, swmq_pkg::ST_OK,    1'b0);
      add_op(swmq_pkg::OP_POP,  32'h0000_0000, 1'b0, 32'h0000_0000, swmq_pkg::ST_OK,    1'b0);

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_ops[i])
         send_request(directed_ops[i].op, directed_ops[i].word, directed_ops[i].typed,
                      directed_ops[i].reply);

      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n == HOLD_OFF_AT) hold_off_pending = 1'b1;
         if (n == RANDOM_REQUESTS - CALM_TAIL) calm_tail = 1'b1;
         // fill to full, mixed, drain to empty, query heavy
         case ((n / SEGMENT_LEN) % 4)
            0: begin
               push_w = 85; pop_w = 7;  peek_w = 4;
            end
            1: begin
               push_w = 40; pop_w = 30; peek_w = 15;
            end
            2: begin
               push_w = 15; pop_w = 65; peek_w = 10;
            end
            default: begin
               push_w = 45; pop_w = 20; peek_w = 10;
            end
         endcase
         pick = $urandom_range(0, 99);
         if (pick < push_w) op = swmq_pkg::OP_PUSH;
         else if (pick < push_w + pop_w) op = swmq_pkg::OP_POP;
         else if (pick < push_w + pop_w + peek_w) op = swmq_pkg::OP_PEEK;
         else op = swmq_pkg::OP_MIN;
         case ($urandom_range(0, 3))
            0: word = 32'($signed($urandom_range(0, 15)) - 8);
            1: begin
               case ($urandom_range(0, 3))
                  0: word = 32'h8000_0000;
                  1: word = 32'h7FFF_FFFF;
                  2: word = 32'h0000_0000;
                  default: word = 32'hFFFF_FFFF;
               endcase
            end
            default: word = $urandom;
         endcase
         send_request(op, word, 1'b0, '0);
      end
      req_tvalid <= 1'b0;

      while (expected_replies.size() != 0) @(posedge clock);
      repeat (swmq_pkg::DEPTH + 8) @(posedge clock);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      @(negedge clock);
      forever begin
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end else if (!calm_tail && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      stack_reply_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_replies.size() == 0) begin
            $display("%0t: response with none expected, actual value %h status %0d empty %b",
                     $time, rsp_tdata, rsp_tuser[1:0], rsp_tuser[2]);
            mismatches++;
         end else begin
            want = expected_replies.pop_front();
            if (rsp_tdata !== want.value) begin
               $display("%0t: result_value expected %h actual %h", $time, want.value,
                        rsp_tdata);
               mismatches++;
            end
            if (rsp_tuser[1:0] !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status,
                        rsp_tuser[1:0]);
               mismatches++;
            end
            if (rsp_tuser[2] !== want.now_empty) begin
               $display("%0t: now_empty expected %b actual %b", $time, want.now_empty,
                        rsp_tuser[2]);
               mismatches++;
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
